// File: hdl/rcr_pkg.sv
// Shared constants, types and the sine table function of the column raycaster.
package rcr_pkg;

  localparam int MAP_SIDE      = 16;
  localparam int CELL_BITS     = 8;
  localparam int SCREEN_HEIGHT = 512;
  localparam int ANGLE_BITS    = 12;
  localparam int QUARTER       = 1024;
  localparam int FINE_PER_UNIT = 3276800;
  localparam int STEP_DIV      = 800;
  localparam logic [30:0] HEIGHT_NUM = 31'd1677721600;
  localparam logic [3:0] EMPTY_CODE = 4'd15;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam logic [2:0] REG_PLAYER_X = 3'd0;
  localparam logic [2:0] REG_PLAYER_Y = 3'd1;
  localparam logic [2:0] REG_ANGLE    = 3'd2;
  localparam logic [2:0] REG_FOV      = 3'd3;
  localparam logic [2:0] REG_STEPS    = 3'd4;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  typedef logic [14:0] sin_tab_t [0:QUARTER];

  typedef struct packed {
    logic        start;
    logic [26:0] den;
  } div_req_t;

  // Quarter-wave sine magnitude in Q1.15, Taylor series through the x^13 term.
  function automatic sin_tab_t sin_table();
    sin_tab_t t;
    longint unsigned r, x, x2, term;
    longint sum, res;
    for (int a = 0; a <= QUARTER; a++) begin
      r    = longint'(a) * 16;
      x    = (r * HALF_PI_Q30) >> 14;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      term = ((term * x2) >> 30) / 6;   sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 20;  sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 42;  sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 72;  sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 110; sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 156; sum = sum + longint'(term);
      if (sum < 0) sum = 0;
      res = (sum + 16384) >>> 15;
      if (res > 32767) res = 32767;
      t[a] = res[14:0];
    end
    return t;
  endfunction

endpackage

// File: hdl/raycast_column_renderer_core.sv
// Top level of the column raycaster: control sequencer, march loop and result register.
// A cast that runs to the step limit goes from the input transfer to the result through
// angle setup and sine lookups through one sine ROM (S_ANGLE, S_TRIG_C, S_TRIG_S, S_TRIG_P,
// S_INIT), then one march step per cycle, set by the single read port of the tile map, then
// the limit check and the load of the output register, which waits while the output stalls.
// A wall hit is resolved in the cycle after its read; unless it is at step zero or the
// cosine of the ray's offset (cp) is not positive, it is followed by a multiply and a wait
// on the bit-serial division (31 quotient bits) for the slice height. A ray that leaves
// the map ends the cast as a miss. One item is worked on at a time; a finished result
// waits in the output register while the next item is taken.
module raycast_column_renderer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [7:0]  cell_index,
  input  logic [3:0]  cell_code,
  input  logic [8:0]  column,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic [3:0]  wall_code,
  output logic [9:0]  slice_top,
  output logic [9:0]  slice_bottom,
  output logic [11:0] steps_taken,
  output logic [7:0]  hit_cell
);

  typedef enum logic [3:0] {
    S_IDLE, S_ANGLE, S_TRIG_C, S_TRIG_S, S_TRIG_P, S_INIT, S_MARCH,
    S_MUL, S_DIV_GO, S_DIV_WAIT, S_SLICE, S_DONE
  } state_t;

  localparam logic signed [22:0] FINE = 23'sd3276800;

  state_t state;
  logic [15:0] eye_x, eye_y;
  logic [11:0] player_angle, max_steps;
  logic [10:0] field_of_view;

  logic [8:0]  col;
  logic [11:0] ray, rel;
  logic [11:0] trig_angle;
  logic signed [15:0] trig_val, c, s, cp;

  logic [11:0] k;
  logic signed [5:0] cx, cy;
  logic signed [22:0] remx, remy;
  logic signed [22:0] nremx, nremy;
  logic signed [5:0]  ncx, ncy;
  logic        pend;
  logic [11:0] pend_k;
  logic [7:0]  pend_cell;
  logic [7:0]  rd_addr;
  logic [3:0]  rd_code;
  logic        out_map;

  logic        r_hit;
  logic [3:0]  r_code;
  logic [9:0]  r_top, r_bottom;
  logic [11:0] r_steps;
  logic [7:0]  r_cell;

  rcr_pkg::div_req_t div_req;
  logic        div_busy, div_done;
  logic [30:0] quo;
  logic [19:0] spread_full;
  logic [11:0] rel_next;
  logic signed [32:0] top_s, bot_s;

  logic accept;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  rcr_sin_rom u_sin (.clk(clk), .angle(trig_angle), .value(trig_val));

  rcr_map u_map (
    .clk(clk), .rst(rst),
    .wr_en(accept && opcode == rcr_pkg::OP_WRITE),
    .wr_addr(cell_index), .wr_data(cell_code),
    .rd_addr(rd_addr), .rd_code(rd_code)
  );

  rcr_div u_div (.clk(clk), .rst(rst), .req(div_req), .busy(div_busy),
                 .done(div_done), .quo(quo));

  always_comb begin
    case (state)
      S_TRIG_C: trig_angle = ray + 12'(rcr_pkg::QUARTER);
      S_TRIG_S: trig_angle = ray;
      default:  trig_angle = rel + 12'(rcr_pkg::QUARTER);
    endcase
  end

  assign spread_full = field_of_view * col;
  assign rel_next    = {1'b0, spread_full[19:9]} - {2'b0, field_of_view[10:1]};

  assign rd_addr = {cy[3:0], cx[3:0]};
  assign out_map = cx[5] || cy[5] || (cx >= 6'sd16) || (cy >= 6'sd16);

  // Each step moves the fine remainder by under one cell, so the cell changes by at most one.
  always_comb begin
    nremx = remx + 23'(c);
    ncx   = cx;
    if (nremx < 0) begin
      nremx = nremx + FINE;
      ncx   = cx - 6'sd1;
    end else if (nremx >= FINE) begin
      nremx = nremx - FINE;
      ncx   = cx + 6'sd1;
    end
    nremy = remy + 23'(s);
    ncy   = cy;
    if (nremy < 0) begin
      nremy = nremy + FINE;
      ncy   = cy - 6'sd1;
    end else if (nremy >= FINE) begin
      nremy = nremy - FINE;
      ncy   = cy + 6'sd1;
    end
  end

  assign top_s = 33'sd256 - $signed({3'b0, quo[30:1]});
  assign bot_s = top_s + $signed({2'b0, quo});

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      pend          <= 1'b0;
      div_req.start <= 1'b0;
      eye_x         <= 16'd14156;
      eye_y         <= 16'd9605;
      player_angle  <= 12'd993;
      field_of_view <= 11'd683;
      max_steps     <= 12'd2000;
    end else begin
      div_req.start <= (state == S_DIV_GO);
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        case (cfg_index)
          rcr_pkg::REG_PLAYER_X: eye_x         <= cfg_data;
          rcr_pkg::REG_PLAYER_Y: eye_y         <= cfg_data;
          rcr_pkg::REG_ANGLE:    player_angle  <= cfg_data[11:0];
          rcr_pkg::REG_FOV:      field_of_view <= cfg_data[10:0];
          rcr_pkg::REG_STEPS:    max_steps     <= cfg_data[11:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (accept && opcode == rcr_pkg::OP_CAST) begin
            col   <= column;
            state <= S_ANGLE;
          end
        end
        S_ANGLE: begin
          rel   <= rel_next;
          ray   <= player_angle + rel_next;
          state <= S_TRIG_C;
        end
        S_TRIG_C: state <= S_TRIG_S;
        S_TRIG_S: begin
          c     <= trig_val;
          state <= S_TRIG_P;
        end
        S_TRIG_P: begin
          s     <= trig_val;
          state <= S_INIT;
        end
        S_INIT: begin
          cp    <= trig_val;
          k     <= '0;
          pend  <= 1'b0;
          cx    <= $signed({2'b0, eye_x[15:12]});
          cy    <= $signed({2'b0, eye_y[15:12]});
          remx  <= $signed(23'(eye_x[11:0] * 10'(rcr_pkg::STEP_DIV)));
          remy  <= $signed(23'(eye_y[11:0] * 10'(rcr_pkg::STEP_DIV)));
          state <= S_MARCH;
        end
        S_MARCH: begin
          // The read issued last cycle belongs to the earlier step and is resolved first.
          if (pend && rd_code != rcr_pkg::EMPTY_CODE) begin
            r_hit   <= 1'b1;
            r_code  <= rd_code;
            r_steps <= pend_k;
            r_cell  <= pend_cell;
            pend    <= 1'b0;
            if (pend_k == '0 || cp <= 0) begin
              r_top    <= '0;
              r_bottom <= 10'(rcr_pkg::SCREEN_HEIGHT);
              state    <= S_DONE;
            end else begin
              state <= S_MUL;
            end
          end else if (k == max_steps) begin
            r_hit    <= 1'b0;
            r_code   <= rcr_pkg::EMPTY_CODE;
            r_top    <= '0;
            r_bottom <= '0;
            r_steps  <= max_steps;
            r_cell   <= pend ? pend_cell : '0;
            pend     <= 1'b0;
            state    <= S_DONE;
          end else if (out_map) begin
            r_hit    <= 1'b0;
            r_code   <= rcr_pkg::EMPTY_CODE;
            r_top    <= '0;
            r_bottom <= '0;
            r_steps  <= k;
            r_cell   <= '0;
            pend     <= 1'b0;
            state    <= S_DONE;
          end else begin
            pend      <= 1'b1;
            pend_k    <= k;
            pend_cell <= rd_addr;
            k         <= k + 12'd1;
            cx        <= ncx;
            cy        <= ncy;
            remx      <= nremx;
            remy      <= nremy;
          end
        end
        S_MUL: begin
          div_req.den <= 27'(r_steps * cp[14:0]);
          state       <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            state <= S_SLICE;
          end
        end
        S_SLICE: begin
          r_top    <= (top_s < 0) ? 10'd0 :
                      (top_s > 33'sd512) ? 10'(rcr_pkg::SCREEN_HEIGHT) : top_s[9:0];
          r_bottom <= (bot_s < 0) ? 10'd0 :
                      (bot_s > 33'sd512) ? 10'(rcr_pkg::SCREEN_HEIGHT) : bot_s[9:0];
          state    <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            hit          <= r_hit;
            wall_code    <= r_code;
            slice_top    <= r_top;
            slice_bottom <= r_bottom;
            steps_taken  <= r_steps;
            hit_cell     <= r_cell;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_MARCH |-> k <= max_steps)
    else $error("march step count passed the limit");

  a_hit_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> wall_code != rcr_pkg::EMPTY_CODE)
    else $error("hit reported with empty wall code");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_busy)
    else $error("divider started while busy");

  a_miss_slice: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> slice_top == '0 && slice_bottom == '0)
    else $error("miss reported with a slice");
`endif

endmodule

// File: hdl/rcr_sin_rom.sv
// Sine lookup with one registered read: full-turn angle to signed Q1.15.
module rcr_sin_rom (
  input  logic                           clk,
  input  logic [rcr_pkg::ANGLE_BITS-1:0] angle,
  output logic signed [15:0]             value
);

  localparam rcr_pkg::sin_tab_t SIN_TAB = rcr_pkg::sin_table();

  logic [10:0] addr;
  logic [14:0] mag;
  logic        neg;

  always_comb begin
    if (angle[10]) begin
      addr = 11'(rcr_pkg::QUARTER) - {1'b0, angle[9:0]};
    end else begin
      addr = {1'b0, angle[9:0]};
    end
  end

  always_ff @(posedge clk) begin
    mag <= SIN_TAB[addr];
    neg <= angle[11];
  end

  assign value = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

// File: hdl/rcr_map.sv
// Tile map store: one write port, one registered read port, valid bits for reset.
module rcr_map (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [rcr_pkg::CELL_BITS-1:0] wr_addr,
  input  logic [3:0]                    wr_data,
  input  logic [rcr_pkg::CELL_BITS-1:0] rd_addr,
  output logic [3:0]                    rd_code
);

  localparam int DEPTH = 1 << rcr_pkg::CELL_BITS;

  logic [3:0]       mem [0:DEPTH-1];
  logic [DEPTH-1:0] written;
  logic [3:0]       code_q;
  logic             vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    code_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      vld_q   <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      vld_q <= written[rd_addr];
    end
  end

  // A cell never written since reset reads as empty.
  assign rd_code = vld_q ? code_q : rcr_pkg::EMPTY_CODE;

endmodule

// File: hdl/rcr_div.sv
// Restoring divider of the fixed height numerator by the distance, one bit a cycle.
module rcr_div (
  input  logic              clk,
  input  logic              rst,
  input  rcr_pkg::div_req_t req,
  output logic              busy,
  output logic              done,
  output logic [30:0]       quo
);

  logic [27:0] rem;
  logic [26:0] den;
  logic [4:0]  cnt;
  logic [27:0] trial;
  logic [28:0] diff;

  assign trial = {rem[26:0], rcr_pkg::HEIGHT_NUM[cnt - 5'd1]};
  assign diff  = {1'b0, trial} - {2'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'd31;
        rem  <= '0;
        den  <= req.den;
        quo  <= '0;
      end else if (busy) begin
        if (!diff[28]) begin
          rem <= diff[27:0];
        end else begin
          rem <= trial;
        end
        quo <= {quo[29:0], ~diff[28]};
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
